[rtl/core/obbsat_pkg.sv]
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared widths, register indexes and a small helper for the oriented box
// separating axis test.
// ----------------------------------------------------------------------------
package obbsat_pkg;

  localparam int CENTER_W = 24;
  localparam int AXIS_W   = 48;
  localparam int COMP_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int LIMIT_W  = 21;
  localparam int DATA_W   = 48;
  localparam int INDEX_W  = 4;

  typedef enum logic [INDEX_W-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_CENTER_Z = 4'd2,
    REG_AXIS_U   = 4'd3,
    REG_AXIS_V   = 4'd4,
    REG_AXIS_W   = 4'd5,
    REG_SIZE     = 4'd6,
    REG_LIMIT    = 4'd7
  } cfg_reg_t;

  localparam logic [AXIS_W-1:0]  AXIS_U_RST = 48'h0000_0000_4000;
  localparam logic [AXIS_W-1:0]  AXIS_V_RST = 48'h0000_4000_0000;
  localparam logic [AXIS_W-1:0]  AXIS_W_RST = 48'h4000_0000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 21'd256;

  // Index k modulo three, for k in 0..5.
  function automatic int unsigned wrap3(input int unsigned k);
    int unsigned r;
    r = (k >= 3) ? k - 3 : k;
    return r;
  endfunction

endpackage

[rtl/core/obb_separating_axis_test_top.sv]
// ----------------------------------------------------------------------------
// obb_separating_axis_test_top
// Fifteen-axis separating axis test of candidate boxes against a configured
// reference box, as a six-stage pipeline in exact fixed point.
// ----------------------------------------------------------------------------
// An item is taken in every cycle that start is high; busy is always low.
// Each item gives one overlap result with a done strobe, in order, one per
// cycle at full rate. The result passes through six register stages: axis
// products, cross axes and dot sums, projection products, projection sums,
// extent products, and the final wide compare.
// The result cannot be held off, so nothing in the pipeline ever stalls.
module obb_separating_axis_test_top
  import obbsat_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [CENTER_W-1:0] cand_center_x,
  input  logic signed [CENTER_W-1:0] cand_center_y,
  input  logic signed [CENTER_W-1:0] cand_center_z,
  input  logic [AXIS_W-1:0]          cand_axis_u,
  input  logic [AXIS_W-1:0]          cand_axis_v,
  input  logic [AXIS_W-1:0]          cand_axis_w,
  input  logic [AXIS_W-1:0]          cand_size,
  input  logic                       cfg_we,
  input  logic [INDEX_W-1:0]         cfg_addr,
  input  logic [DATA_W-1:0]          cfg_data,
  output logic                       done,
  output logic                       overlap
);

  localparam int LW   = CENTER_W + 1;       // center difference
  localparam int PRW  = 2 * COMP_W;         // axis by axis product
  localparam int PW   = PRW + 1;            // cross axis component
  localparam int RMW  = PRW;                // |axis dot axis|
  localparam int LAW  = LW + COMP_W;        // l by axis component product
  localparam int LDW  = LAW + 1;            // l dot axis
  localparam int FPW  = RMW + SIZE_W;       // face extent term
  localparam int FRW  = 50;                 // face extent sum
  localparam int EPW  = COMP_W + PW;        // axis by cross component product
  localparam int ESW  = EPW + 1;            // axis dot cross
  localparam int EMW  = 48;                 // |axis dot cross|
  localparam int LPW  = LW + PW;            // l by cross component product
  localparam int LSW  = LPW + 1;            // l dot cross
  localparam int LMW  = 57;                 // |l dot cross|
  localparam int ETW  = EMW + SIZE_W;       // edge extent term
  localparam int EXW  = ETW + 2;            // edge extent sum
  localparam int ELW  = LMW + 11;           // scaled edge distance

  // Configuration registers.
  logic signed [CENTER_W-1:0] ref_center_x, ref_center_y, ref_center_z;
  logic [AXIS_W-1:0]          ref_axis_u, ref_axis_v, ref_axis_w, ref_size;
  logic [LIMIT_W-1:0]         parallel_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_center_x   <= '0;
      ref_center_y   <= '0;
      ref_center_z   <= '0;
      ref_axis_u     <= AXIS_U_RST;
      ref_axis_v     <= AXIS_V_RST;
      ref_axis_w     <= AXIS_W_RST;
      ref_size       <= '0;
      parallel_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_X: ref_center_x   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: ref_center_y   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Z: ref_center_z   <= cfg_data[CENTER_W-1:0];
        REG_AXIS_U:   ref_axis_u     <= cfg_data[AXIS_W-1:0];
        REG_AXIS_V:   ref_axis_v     <= cfg_data[AXIS_W-1:0];
        REG_AXIS_W:   ref_axis_w     <= cfg_data[AXIS_W-1:0];
        REG_SIZE:     ref_size       <= cfg_data[AXIS_W-1:0];
        REG_LIMIT:    parallel_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Unpacked reference and candidate boxes.
  logic signed [COMP_W-1:0] ra [3][3];
  logic [SIZE_W-1:0]        rs [3];
  logic signed [COMP_W-1:0] qa_in [3][3];
  logic [SIZE_W-1:0]        qs_in [3];
  logic signed [LW-1:0]     l_in [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ra[0][c]    = ref_axis_u[COMP_W*c +: COMP_W];
      ra[1][c]    = ref_axis_v[COMP_W*c +: COMP_W];
      ra[2][c]    = ref_axis_w[COMP_W*c +: COMP_W];
      rs[c]       = ref_size[SIZE_W*c +: SIZE_W];
      qa_in[0][c] = cand_axis_u[COMP_W*c +: COMP_W];
      qa_in[1][c] = cand_axis_v[COMP_W*c +: COMP_W];
      qa_in[2][c] = cand_axis_w[COMP_W*c +: COMP_W];
      qs_in[c]    = cand_size[SIZE_W*c +: SIZE_W];
    end
    l_in[0] = LW'(ref_center_x) - LW'(cand_center_x);
    l_in[1] = LW'(ref_center_y) - LW'(cand_center_y);
    l_in[2] = LW'(ref_center_z) - LW'(cand_center_z);
  end

  logic [6:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:1], start};
    end
  end

  // Stage 1: all axis by axis products.
  logic signed [PRW-1:0] s1_xp [3][3][3][2];
  logic signed [PRW-1:0] s1_dp [3][3][3];
  logic signed [PRW-1:0] s1_xp_next [3][3][3][2];
  logic signed [PRW-1:0] s1_dp_next [3][3][3];
  logic signed [COMP_W-1:0] s1_qa [3][3];
  logic [SIZE_W-1:0]        s1_qs [3];
  logic signed [LW-1:0]     s1_l [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          s1_xp_next[i][j][c][0] = ra[i][wrap3(c+1)] * qa_in[j][wrap3(c+2)];
          s1_xp_next[i][j][c][1] = ra[i][wrap3(c+2)] * qa_in[j][wrap3(c+1)];
          s1_dp_next[i][j][c]    = ra[i][c] * qa_in[j][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_xp <= s1_xp_next;
    s1_dp <= s1_dp_next;
    s1_qa <= qa_in;
    s1_qs <= qs_in;
    s1_l  <= l_in;
  end

  // Stage 2: cross axes and magnitudes of the axis dot matrix.
  logic signed [PW-1:0]     s2_p [3][3][3];
  logic [RMW-1:0]           s2_rm [3][3];
  logic signed [PW-1:0]     s2_p_next [3][3][3];
  logic [RMW-1:0]           s2_rm_next [3][3];
  logic signed [COMP_W-1:0] s2_qa [3][3];
  logic [SIZE_W-1:0]        s2_qs [3];
  logic signed [LW-1:0]     s2_l [3];

  always_comb begin
    logic signed [PW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          s2_p_next[i][j][c] = PW'(s1_xp[i][j][c][0]) - PW'(s1_xp[i][j][c][1]);
        end
        sum = PW'(s1_dp[i][j][0]) + PW'(s1_dp[i][j][1]) + PW'(s1_dp[i][j][2]);
        if (sum < 0) sum = -sum;
        s2_rm_next[i][j] = sum[RMW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_p  <= s2_p_next;
    s2_rm <= s2_rm_next;
    s2_qa <= s1_qa;
    s2_qs <= s1_qs;
    s2_l  <= s1_l;
  end

  // Stage 3: projection products and the parallel edge flags.
  // Face f is reference axis f for f < 3, candidate axis f-3 otherwise.
  logic signed [LAW-1:0] s3_la [6][3];
  logic [FPW-1:0]        s3_fp [6][3];
  logic signed [EPW-1:0] s3_ep [3][3][4][3];
  logic signed [LPW-1:0] s3_lp [3][3][3];
  logic [2:0]            s3_par [3];
  logic signed [LAW-1:0] s3_la_next [6][3];
  logic [FPW-1:0]        s3_fp_next [6][3];
  logic signed [EPW-1:0] s3_ep_next [3][3][4][3];
  logic signed [LPW-1:0] s3_lp_next [3][3][3];
  logic [2:0]            s3_par_next [3];
  logic [SIZE_W-1:0]     s3_qs [3];

  always_comb begin
    logic signed [PW-1:0] pa;
    logic                 small_all;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        s3_la_next[k][c]   = s2_l[c] * ra[k][c];
        s3_la_next[k+3][c] = s2_l[c] * s2_qa[k][c];
        s3_fp_next[k][c]   = s2_rm[k][c] * s2_qs[c];
        s3_fp_next[k+3][c] = s2_rm[c][k] * rs[c];
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        small_all = 1'b1;
        for (int c = 0; c < 3; c++) begin
          pa = (s2_p[i][j][c] < 0) ? -s2_p[i][j][c] : s2_p[i][j][c];
          if (pa > PW'(parallel_limit)) small_all = 1'b0;
          s3_ep_next[i][j][0][c] = ra[wrap3(i+1)][c] * s2_p[i][j][c];
          s3_ep_next[i][j][1][c] = ra[wrap3(i+2)][c] * s2_p[i][j][c];
          s3_ep_next[i][j][2][c] = s2_qa[wrap3(j+1)][c] * s2_p[i][j][c];
          s3_ep_next[i][j][3][c] = s2_qa[wrap3(j+2)][c] * s2_p[i][j][c];
          s3_lp_next[i][j][c]    = s2_l[c] * s2_p[i][j][c];
        end
        s3_par_next[i][j] = small_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_la  <= s3_la_next;
    s3_fp  <= s3_fp_next;
    s3_ep  <= s3_ep_next;
    s3_lp  <= s3_lp_next;
    s3_par <= s3_par_next;
    s3_qs  <= s2_qs;
  end

  // Stage 4: projection sums and magnitudes.
  logic [LDW-2:0]    s4_fl [6];
  logic [FRW-1:0]    s4_fr [6];
  logic [EMW-1:0]    s4_em [3][3][4];
  logic [LMW-1:0]    s4_ld [3][3];
  logic [LDW-2:0]    s4_fl_next [6];
  logic [FRW-1:0]    s4_fr_next [6];
  logic [EMW-1:0]    s4_em_next [3][3][4];
  logic [LMW-1:0]    s4_ld_next [3][3];
  logic [2:0]        s4_par [3];
  logic [SIZE_W-1:0] s4_qs [3];

  always_comb begin
    logic signed [LDW-1:0] dl;
    logic signed [ESW-1:0] de;
    logic signed [LSW-1:0] dp;
    logic [SIZE_W-1:0]     own;
    for (int f = 0; f < 6; f++) begin
      dl = LDW'(s3_la[f][0]) + LDW'(s3_la[f][1]) + LDW'(s3_la[f][2]);
      if (dl < 0) dl = -dl;
      s4_fl_next[f] = dl[LDW-2:0];
      own = (f < 3) ? rs[wrap3(f)] : s3_qs[wrap3(f)];
      s4_fr_next[f] = {6'd0, own, 28'd0} + FRW'(s3_fp[f][0]) + FRW'(s3_fp[f][1])
                      + FRW'(s3_fp[f][2]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 4; k++) begin
          de = ESW'(s3_ep[i][j][k][0]) + ESW'(s3_ep[i][j][k][1])
               + ESW'(s3_ep[i][j][k][2]);
          if (de < 0) de = -de;
          s4_em_next[i][j][k] = de[EMW-1:0];
        end
        dp = LSW'(s3_lp[i][j][0]) + LSW'(s3_lp[i][j][1]) + LSW'(s3_lp[i][j][2]);
        if (dp < 0) dp = -dp;
        s4_ld_next[i][j] = dp[LMW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_fl  <= s4_fl_next;
    s4_fr  <= s4_fr_next;
    s4_em  <= s4_em_next;
    s4_ld  <= s4_ld_next;
    s4_par <= s3_par;
    s4_qs  <= s3_qs;
  end

  // Stage 5: face verdicts and edge extent products.
  logic [5:0]     s5_fpass;
  logic [ETW-1:0] s5_et [3][3][4];
  logic [5:0]     s5_fpass_next;
  logic [ETW-1:0] s5_et_next [3][3][4];
  logic [LMW-1:0] s5_ld [3][3];
  logic [2:0]     s5_par [3];

  always_comb begin
    for (int f = 0; f < 6; f++) begin
      s5_fpass_next[f] = {s4_fl[f], 11'd0} < (LDW+10)'(s4_fr[f]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s5_et_next[i][j][0] = s4_em[i][j][0] * rs[wrap3(i+1)];
        s5_et_next[i][j][1] = s4_em[i][j][1] * rs[wrap3(i+2)];
        s5_et_next[i][j][2] = s4_em[i][j][2] * s4_qs[wrap3(j+1)];
        s5_et_next[i][j][3] = s4_em[i][j][3] * s4_qs[wrap3(j+2)];
      end
    end
  end

  always_ff @(posedge clk) begin
    s5_fpass <= s5_fpass_next;
    s5_et    <= s5_et_next;
    s5_ld    <= s4_ld;
    s5_par   <= s4_par;
  end

  // Stage 6: wide edge compares; a near-parallel edge pair never separates.
  logic overlap_next;

  always_comb begin
    logic [EXW-1:0] ext;
    overlap_next = &s5_fpass;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ext = EXW'(s5_et[i][j][0]) + EXW'(s5_et[i][j][1]) + EXW'(s5_et[i][j][2])
              + EXW'(s5_et[i][j][3]);
        if (!s5_par[i][j] && !({s5_ld[i][j], 11'd0} < ELW'(ext))) begin
          overlap_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    overlap <= overlap_next;
  end

  assign done = vld[6];

endmodule
